[rtl/core/smv_pkg.sv]
// shared types, constants and saturation helpers for the 3x3 block sparse mat-vec
package smv_pkg;

  localparam int MAX_NODES = 4096;
  localparam int FRAC_BITS = 16;
  localparam int NODE_W    = 12;
  localparam int WORD_W    = 32;
  localparam int ACC_W     = 64;
  localparam int ADDR_W    = $clog2(MAX_NODES);

  // command codes; the fourth code is unused
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_BLOCK   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  typedef logic [2:0][WORD_W-1:0] vec_t;
  typedef logic [2:0][ACC_W-1:0]  acc_vec_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [NODE_W-1:0] node;
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] v2;
    logic [WORD_W-1:0] v3;
    logic [WORD_W-1:0] v4;
    logic [WORD_W-1:0] v5;
    logic [WORD_W-1:0] v6;
    logic [WORD_W-1:0] v7;
    logic [WORD_W-1:0] v8;
    logic              last_in_row;
  } in_beat_t;

  typedef struct packed {
    logic [NODE_W-1:0] row_index;
    logic [WORD_W-1:0] res_x;
    logic [WORD_W-1:0] res_y;
    logic [WORD_W-1:0] res_z;
  } out_beat_t;

  // per-lane control from the sequencer
  typedef struct packed {
    logic       load;
    logic       add;
    logic [1:0] col;
    logic       clear;
  } lane_ctrl_t;

  // signed add clamped to the 64-bit range
  function automatic logic [ACC_W-1:0] sat_add64(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
    logic [ACC_W-1:0] s;
    s = a + b;
    if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
      s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s;
  endfunction

  // clamp a 64-bit signed value to 32 bits
  function automatic logic [WORD_W-1:0] sat32(input logic [ACC_W-1:0] a);
    logic [WORD_W-1:0] r;
    if (&a[ACC_W-1:WORD_W-1] || ~|a[ACC_W-1:WORD_W-1]) begin
      r = a[WORD_W-1:0];
    end else begin
      r = a[ACC_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[rtl/core/smv_vstore.sv]
// per-node vector store, one 3-word row per node, registered read
module smv_vstore import smv_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  vec_t              wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output vec_t              rdata
);

  vec_t mem [MAX_NODES];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/smv_lane.sv]
// one block row: three multipliers and a saturating row accumulator
module smv_lane import smv_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  lane_ctrl_t       ctrl,
  input  vec_t             row,
  input  vec_t             x,
  output logic [ACC_W-1:0] acc
);

  logic signed [ACC_W-1:0] prod [3];
  logic signed [ACC_W-1:0] term;

  // full-precision products, registered
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int c = 0; c < 3; c++) begin
        prod[c] <= $signed(row[c]) * $signed(x[c]);
      end
    end
  end

  // rescale the selected product, floor rounding
  always_comb begin
    case (ctrl.col)
      2'd0:    term = prod[0] >>> FRAC_BITS;
      2'd1:    term = prod[1] >>> FRAC_BITS;
      default: term = prod[2] >>> FRAC_BITS;
    endcase
  end

  // one saturating add per cycle while add is set, column order
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.add) begin
      acc <= sat_add64(acc, term);
    end
  end

endmodule

[rtl/core/smv_merge.sv]
// merges lane accumulators into a saturated result beat with an output register
module smv_merge import smv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [NODE_W-1:0] row_index,
  input  acc_vec_t          accs,
  output logic              free,
  output logic              result_valid,
  input  logic              result_ready,
  output out_beat_t         result
);

  assign free = !result_valid || result_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      result.row_index <= row_index;
      result.res_x     <= sat32(accs[0]);
      result.res_y     <= sat32(accs[1]);
      result.res_z     <= sat32(accs[2]);
    end
  end

endmodule

[rtl/core/block3x3_sparse_matvec.sv]
// top level: 3x3 block sparse matrix times vector with three row lanes
//
//  channel  | signals                          | beat
//  ---------+----------------------------------+-------------------------------
//  item     | item_valid, item_ready, item     | command, node, 3x3 block, last
//  result   | result_valid, result_ready, ...  | row index and saturated row
//
// vector write, restart and unused commands keep the sequencer in idle
// a block runs vector read, multiply, then 3 saturating adds per lane
// a block ending a row then loads the output register from S_EMIT once it is free
// the three saturating adds in each lane are dependent and run one column at a time
// reset clears the sequencer, row counter and accumulators; the vector store is not cleared
// a stalled result holds in the output register while the next item is taken
module block3x3_sparse_matvec import smv_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  in_beat_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output out_beat_t result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_EMIT
  } state_t;

  state_t            state;
  logic [1:0]        col;
  logic [NODE_W-1:0] row_cnt;

  logic              fire;
  logic              in_range;
  logic              blk_last;
  logic              blk_in_range;
  vec_t              blk_row [3];
  vec_t              vec_rd;
  vec_t              x_vec;
  acc_vec_t          accs;
  lane_ctrl_t        lane_ctrl;
  logic              merge_free;
  logic              emit;
  logic              restart;

  assign item_ready = (state == S_IDLE);
  assign fire       = item_valid && item_ready;
  assign in_range   = (32'(item.node) < MAX_NODES);
  assign restart    = fire && (cmd_e'(item.cmd) == CMD_RESTART);
  assign emit       = (state == S_EMIT) && merge_free;

  // sequencer, col and row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      col     <= '0;
      row_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          col <= '0;
          if (fire) begin
            case (item.cmd)
              CMD_BLOCK:   state   <= S_MUL;
              CMD_RESTART: row_cnt <= '0;
              default:     state   <= S_IDLE;
            endcase
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (col == 2'd2) begin
            state <= blk_last ? S_EMIT : S_IDLE;
            col   <= '0;
          end else begin
            col <= col + 2'd1;
          end
        end
        S_EMIT: begin
          if (merge_free) begin
            state   <= S_IDLE;
            row_cnt <= (32'(row_cnt) == MAX_NODES - 1) ? '0 : row_cnt + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // latch the block of the accepted item
  always_ff @(posedge clk) begin
    if (fire && cmd_e'(item.cmd) == CMD_BLOCK) begin
      blk_row[0]   <= {item.v2, item.v1, item.v0};
      blk_row[1]   <= {item.v5, item.v4, item.v3};
      blk_row[2]   <= {item.v8, item.v7, item.v6};
      blk_last     <= item.last_in_row;
      blk_in_range <= in_range;
    end
  end

  smv_vstore u_vstore (
    .clk   (clk),
    .we    (fire && cmd_e'(item.cmd) == CMD_WRITE && in_range),
    .waddr (ADDR_W'(item.node)),
    .wdata ({item.v2, item.v1, item.v0}),
    .re    (fire && cmd_e'(item.cmd) == CMD_BLOCK),
    .raddr (ADDR_W'(item.node)),
    .rdata (vec_rd)
  );

  // out-of-range column node reads a zero vector
  assign x_vec = blk_in_range ? vec_rd : '0;

  // lane control
  always_comb begin
    lane_ctrl.load  = (state == S_MUL);
    lane_ctrl.add   = (state == S_ACC);
    lane_ctrl.col   = col;
    lane_ctrl.clear = restart || emit;
  end

  // one lane per block row
  for (genvar r = 0; r < 3; r++) begin : g_lane
    smv_lane u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctrl (lane_ctrl),
      .row  (blk_row[r]),
      .x    (x_vec),
      .acc  (accs[r])
    );
  end

  smv_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (emit),
    .row_index    (row_cnt),
    .accs         (accs),
    .free         (merge_free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

[rtl/core/smv_checker.sv]
// port-level checks for the block sparse mat-vec, bound to the top level
module smv_checker import smv_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      item_valid,
  input logic      item_ready,
  input in_beat_t  item,
  input logic      result_valid,
  input logic      result_ready,
  input out_beat_t result
);

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // a block beat occupies the datapath
  a_block_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.cmd == CMD_BLOCK |=> !item_ready)
    else $error("item taken while a block is in progress");

  // writes, restarts and unused codes leave the input ready
  a_short_cmd: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.cmd != CMD_BLOCK |=> item_ready)
    else $error("non-block command held the input");

  // a new result only comes out of block work
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!item_ready))
    else $error("result appeared without block work");

endmodule

bind block3x3_sparse_matvec smv_checker u_smv_checker (.*);
